### rtl/abcq_pkg.sv
package abcq_pkg;

    localparam int PROB_W      = 16;
    localparam int CHAR_W      = 7;
    localparam int SCALE_BITS  = 24;
    localparam int SCALED_W    = SCALE_BITS + 1;
    localparam int QUAL_MAX    = 40;
    localparam int QUAL_IDX_W  = 6;
    localparam logic [CHAR_W-1:0] QUAL_OFFSET = 7'd33;

    typedef enum logic [2:0] {
        CLS_GAP = 3'd0,
        CLS_A   = 3'd1,
        CLS_C   = 3'd2,
        CLS_G   = 3'd3,
        CLS_T   = 3'd4
    } class_t;

    function automatic logic [CHAR_W-1:0] class_label(input class_t cls);
        logic [CHAR_W-1:0] label;
        case (cls)
            CLS_GAP: label = 7'd42;
            CLS_A:   label = 7'd65;
            CLS_C:   label = 7'd67;
            CLS_G:   label = 7'd71;
            CLS_T:   label = 7'd84;
            default: label = 7'd42;
        endcase
        return label;
    endfunction

    // Entry q-1 is floor(2^24 * 10^(-q/10)) for quality q.
    function automatic logic [SCALED_W-1:0] qual_thresh(input logic [QUAL_IDX_W-1:0] idx);
        logic [SCALED_W-1:0] t;
        case (idx)
            6'd0:    t = 25'd13326616;
            6'd1:    t = 25'd10585707;
            6'd2:    t = 25'd8408526;
            6'd3:    t = 25'd6679129;
            6'd4:    t = 25'd5305421;
            6'd5:    t = 25'd4214246;
            6'd6:    t = 25'd3347494;
            6'd7:    t = 25'd2659009;
            6'd8:    t = 25'd2112126;
            6'd9:    t = 25'd1677721;
            6'd10:   t = 25'd1332661;
            6'd11:   t = 25'd1058570;
            6'd12:   t = 25'd840852;
            6'd13:   t = 25'd667912;
            6'd14:   t = 25'd530542;
            6'd15:   t = 25'd421424;
            6'd16:   t = 25'd334749;
            6'd17:   t = 25'd265900;
            6'd18:   t = 25'd211212;
            6'd19:   t = 25'd167772;
            6'd20:   t = 25'd133266;
            6'd21:   t = 25'd105857;
            6'd22:   t = 25'd84085;
            6'd23:   t = 25'd66791;
            6'd24:   t = 25'd53054;
            6'd25:   t = 25'd42142;
            6'd26:   t = 25'd33474;
            6'd27:   t = 25'd26590;
            6'd28:   t = 25'd21121;
            6'd29:   t = 25'd16777;
            6'd30:   t = 25'd13326;
            6'd31:   t = 25'd10585;
            6'd32:   t = 25'd8408;
            6'd33:   t = 25'd6679;
            6'd34:   t = 25'd5305;
            6'd35:   t = 25'd4214;
            6'd36:   t = 25'd3347;
            6'd37:   t = 25'd2659;
            6'd38:   t = 25'd2112;
            6'd39:   t = 25'd1677;
            default: t = 25'd0;
        endcase
        return t;
    endfunction

endpackage

### rtl/abcq_argmax.sv
module abcq_argmax
    import abcq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PROB_W-1:0] prob_gap,
    input  logic [PROB_W-1:0] prob_a,
    input  logic [PROB_W-1:0] prob_c,
    input  logic [PROB_W-1:0] prob_g,
    input  logic [PROB_W-1:0] prob_t,
    input  logic              last_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PROB_W-1:0] best_prob,
    output class_t            best_cls,
    output logic              last_out
);

    logic              s1_valid_reg;
    logic [PROB_W-1:0] s1_p01_reg;
    class_t            s1_c01_reg;
    logic [PROB_W-1:0] s1_p23_reg;
    class_t            s1_c23_reg;
    logic [PROB_W-1:0] s1_pt_reg;
    logic              s1_last_reg;

    logic              s2_valid_reg;
    logic [PROB_W-1:0] s2_prob_reg;
    class_t            s2_cls_reg;
    logic              s2_last_reg;

    logic              s1_adv;
    logic              s2_adv;
    logic              a_gt;
    logic              g_gt;
    logic              hi_gt;
    logic [PROB_W-1:0] w_prob;
    class_t            w_cls;

    assign s2_adv   = !s2_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    // Strict compares keep ties on the lower class index.
    assign a_gt  = prob_a > prob_gap;
    assign g_gt  = prob_g > prob_c;
    assign hi_gt = s1_p23_reg > s1_p01_reg;

    always_comb
    begin
        w_prob = hi_gt ? s1_p23_reg : s1_p01_reg;
        w_cls  = hi_gt ? s1_c23_reg : s1_c01_reg;
        if (s1_pt_reg > w_prob)
        begin
            w_prob = s1_pt_reg;
            w_cls  = CLS_T;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_p01_reg  <= a_gt ? prob_a : prob_gap;
            s1_c01_reg  <= a_gt ? CLS_A : CLS_GAP;
            s1_p23_reg  <= g_gt ? prob_g : prob_c;
            s1_c23_reg  <= g_gt ? CLS_G : CLS_C;
            s1_pt_reg   <= prob_t;
            s1_last_reg <= last_in;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_prob_reg <= w_prob;
            s2_cls_reg  <= w_cls;
            s2_last_reg <= s1_last_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign best_prob = s2_prob_reg;
    assign best_cls  = s2_cls_reg;
    assign last_out  = s2_last_reg;

endmodule

### rtl/abcq_phred.sv
module abcq_phred
    import abcq_pkg::*;
#(
    parameter int PROB_FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PROB_W-1:0] best_prob,
    input  class_t            best_cls,
    input  logic              last_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] base_char,
    output logic [CHAR_W-1:0] quality_char,
    output logic              sample_end
);

    localparam logic [SCALED_W-1:0] ONE   = SCALED_W'(1) << PROB_FRAC_BITS;
    localparam int                  SHIFT = SCALE_BITS - PROB_FRAC_BITS;

    logic                s3_valid_reg;
    logic [QUAL_MAX-1:0] s3_pass_reg;
    class_t              s3_cls_reg;
    logic                s3_last_reg;

    logic                s4_valid_reg;
    logic [CHAR_W-1:0]   s4_base_reg;
    logic [CHAR_W-1:0]   s4_qual_reg;
    logic                s4_end_reg;

    logic                s3_adv;
    logic                s4_adv;
    logic [SCALED_W-1:0] score;
    logic [SCALED_W-1:0] rest;
    logic [SCALED_W-1:0] scaled;
    logic [QUAL_MAX-1:0] pass;

    assign s4_adv   = !s4_valid_reg || out_ready;
    assign s3_adv   = !s3_valid_reg || s4_adv;
    assign in_ready = s3_adv;

    // A score of one or more is held just below one for the quality.
    always_comb
    begin
        score = SCALED_W'(best_prob);
        if (score >= ONE)
        begin
            score = ONE - SCALED_W'(1);
        end
        rest   = ONE - score;
        scaled = rest << SHIFT;
        for (int i = 0; i < QUAL_MAX; i++)
        begin
            pass[i] = scaled <= qual_thresh(QUAL_IDX_W'(i));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_adv)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s4_adv)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv && in_valid)
        begin
            s3_pass_reg <= pass;
            s3_cls_reg  <= best_cls;
            s3_last_reg <= last_in;
        end
        if (s4_adv && s3_valid_reg)
        begin
            s4_base_reg <= class_label(s3_cls_reg);
            s4_qual_reg <= CHAR_W'($countones(s3_pass_reg)) + QUAL_OFFSET;
            s4_end_reg  <= s3_last_reg;
        end
    end

    assign out_valid    = s4_valid_reg;
    assign base_char    = s4_base_reg;
    assign quality_char = s4_qual_reg;
    assign sample_end   = s4_end_reg;

endmodule

### rtl/argmax_base_call_with_quality.sv
// Channel   Direction  Contents
// s_axis    in         five 16-bit class scores in tdata, last position in tlast
// m_axis    out        base and quality characters in tdata, end of sample in tlast
//
// One word is taken per cycle unless m_axis_tready stalls a full pipeline.
// The four stages are two compare levels of the argmax, the quality threshold
// compares and the quality count with the output register.
// Reset empties the pipeline; no other state is held.
// A stall moves back stage by stage, so gaps in the pipeline are filled first.
module argmax_base_call_with_quality
    import abcq_pkg::*;
#(
    parameter int PROB_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // prob_gap, prob_a, prob_c, prob_g, prob_t
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // base_char, quality_char, two zero bits
    output logic        m_axis_tlast
);

    logic              mid_valid;
    logic              mid_ready;
    logic [PROB_W-1:0] mid_prob;
    class_t            mid_cls;
    logic              mid_last;
    logic [CHAR_W-1:0] base_char;
    logic [CHAR_W-1:0] quality_char;

    abcq_argmax u_argmax (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .prob_gap  (s_axis_tdata[15:0]),
        .prob_a    (s_axis_tdata[31:16]),
        .prob_c    (s_axis_tdata[47:32]),
        .prob_g    (s_axis_tdata[63:48]),
        .prob_t    (s_axis_tdata[79:64]),
        .last_in   (s_axis_tlast),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .best_prob (mid_prob),
        .best_cls  (mid_cls),
        .last_out  (mid_last)
    );

    abcq_phred #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_phred (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mid_valid),
        .in_ready     (mid_ready),
        .best_prob    (mid_prob),
        .best_cls     (mid_cls),
        .last_in      (mid_last),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .base_char    (base_char),
        .quality_char (quality_char),
        .sample_end   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, quality_char, base_char};

    a_qual_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:7] >= 7'd33) && (m_axis_tdata[13:7] <= 7'd73))
        else $error("quality character out of range");

    a_base_label: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] == 7'd42) || (m_axis_tdata[6:0] == 7'd65)
                       || (m_axis_tdata[6:0] == 7'd67) || (m_axis_tdata[6:0] == 7'd71)
                       || (m_axis_tdata[6:0] == 7'd84))
        else $error("base character is not a class label");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("stalled result word changed");

endmodule

### sim/argmax_base_call_with_quality_tb.sv
`timescale 1ns / 100ps

module argmax_base_call_with_quality_tb
    import abcq_pkg::*;
();

    localparam int PROB_FRAC_BITS = 16;
    localparam int NUM_CLASSES    = 5;
    localparam int RANDOM_PER_SET = 125;
    localparam int SQUEEZE_ITEMS  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    // Largest scaled remainder 2^24 * (1 - p) that still earns quality q, for q = 1..40.
    localparam int unsigned PHRED_LIMIT [QUAL_MAX] = '{
        13326616, 10585707, 8408526, 6679129, 5305421,
        4214246, 3347494, 2659009, 2112126, 1677721,
        1332661, 1058570, 840852, 667912, 530542,
        421424, 334749, 265900, 211212, 167772,
        133266, 105857, 84085, 66791, 53054,
        42142, 33474, 26590, 21121, 16777,
        13326, 10585, 8408, 6679, 5305,
        4214, 3347, 2659, 2112, 1677
    };

    typedef struct packed {
        logic                               last;
        logic [NUM_CLASSES-1:0][PROB_W-1:0] score;
    } position_t;

    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
        logic [CHAR_W-1:0] quality_char;
        logic              sample_end;
    } base_call_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // prob_gap, prob_a, prob_c, prob_g, prob_t
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // base_char, quality_char, two zero bits
    logic        m_axis_tlast;

    position_t  pending_positions [$];
    base_call_t expected_calls [$];
    position_t  offered;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic squeeze_start = 1'b0;
    logic hold_off = 1'b0;

    int  cycles = 0;
    int  mismatches = 0;
    int  positions_sent = 0;
    int  calls_checked = 0;
    int  top_quality_calls = 0;
    int  zero_quality_calls = 0;
    int  sample_ends = 0;
    int  input_stalls = 0;

    argmax_base_call_with_quality #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic base_call_t call_base(input position_t pos);
        base_call_t        call;
        class_t            winner;
        logic [PROB_W-1:0] top;
        logic [63:0]       one;
        logic [63:0]       capped;
        logic [63:0]       scaled;
        int                quality;
        winner = CLS_GAP;
        top = pos.score[0];
        for (int k = 1; k < NUM_CLASSES; k++)
        begin
            if (pos.score[k] > top)
            begin
                top = pos.score[k];
                winner = class_t'(k);
            end
        end
        case (winner)
            CLS_A:   call.base_char = CHAR_W'("A");
            CLS_C:   call.base_char = CHAR_W'("C");
            CLS_G:   call.base_char = CHAR_W'("G");
            CLS_T:   call.base_char = CHAR_W'("T");
            default: call.base_char = CHAR_W'("*");
        endcase
        // A score of one or more is read as the largest fraction below one.
        one = 64'd1 << PROB_FRAC_BITS;
        capped = (64'(top) >= one) ? one - 64'd1 : 64'(top);
        scaled = (one - capped) << (SCALE_BITS - PROB_FRAC_BITS);
        quality = 0;
        for (int q = 0; q < QUAL_MAX; q++)
        begin
            if (scaled <= 64'(PHRED_LIMIT[q]))
                quality++;
        end
        call.quality_char = CHAR_W'(quality) + QUAL_OFFSET;
        call.sample_end = pos.last;
        return call;
    endfunction

    function automatic position_t make_position(
        input logic [PROB_W-1:0] gap_score,
        input logic [PROB_W-1:0] a_score,
        input logic [PROB_W-1:0] c_score,
        input logic [PROB_W-1:0] g_score,
        input logic [PROB_W-1:0] t_score,
        input logic              last
    );
        position_t pos;
        pos.score[CLS_GAP] = gap_score;
        pos.score[CLS_A]   = a_score;
        pos.score[CLS_C]   = c_score;
        pos.score[CLS_G]   = g_score;
        pos.score[CLS_T]   = t_score;
        pos.last = last;
        return pos;
    endfunction

    function automatic position_t random_position();
        position_t         pos;
        logic [63:0]       rest;
        logic [PROB_W-1:0] top;
        int                q;
        int                winner;
        pos.last = ($urandom_range(3) == 0);
        case ($urandom_range(3))
            0:
            begin
                for (int k = 0; k < NUM_CLASSES; k++)
                    pos.score[k] = PROB_W'($urandom);
            end
            1:
            begin
                // Aim the winner at either side of a quality step.
                q = $urandom_range(1, QUAL_MAX);
                rest = 64'(PHRED_LIMIT[q-1] >> (SCALE_BITS - PROB_FRAC_BITS));
                rest = rest + $urandom_range(0, 2);
                rest = (rest > 64'd1) ? rest - 64'd1 : 64'd1;
                top = PROB_W'((64'd1 << PROB_FRAC_BITS) - rest);
                winner = $urandom_range(NUM_CLASSES - 1);
                for (int k = 0; k < NUM_CLASSES; k++)
                    pos.score[k] = (k == winner) ? top : PROB_W'($urandom_range(0, top));
            end
            2:
            begin
                top = PROB_W'($urandom);
                for (int k = 0; k < NUM_CLASSES; k++)
                    pos.score[k] = $urandom_range(1) ? top : PROB_W'($urandom_range(0, top));
            end
            default:
            begin
                for (int k = 0; k < NUM_CLASSES; k++)
                begin
                    case ($urandom_range(2))
                        0:       pos.score[k] = '0;
                        1:       pos.score[k] = '1;
                        default: pos.score[k] = PROB_W'($urandom);
                    endcase
                end
            end
        endcase
        return pos;
    endfunction

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_calls = {expected_calls, call_base(offered)};
                positions_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
                input_stalls++;
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_positions.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_positions.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= offered.score;
                    s_axis_tlast  <= offered.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_calls.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Unexpected word: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    base_call_t want;
                    want = expected_calls.pop_front();
                    calls_checked++;
                    if (want.quality_char == QUAL_OFFSET + CHAR_W'(QUAL_MAX))
                        top_quality_calls++;
                    if (want.quality_char == QUAL_OFFSET)
                        zero_quality_calls++;
                    if (want.sample_end)
                        sample_ends++;
                    if (m_axis_tdata[6:0] !== want.base_char
                        || m_axis_tdata[13:7] !== want.quality_char
                        || m_axis_tdata[15:14] !== 2'b00
                        || m_axis_tlast !== want.sample_end)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("Call %0d: expected base %h quality %h pad 0 end %b,",
                                     calls_checked, want.base_char, want.quality_char,
                                     want.sample_end);
                            $display("    got base %h quality %h pad %b end %b",
                                     m_axis_tdata[6:0], m_axis_tdata[13:7],
                                     m_axis_tdata[15:14], m_axis_tlast);
                        end
                    end
                end
            end
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The receiver is held off for a long stretch so that the pipeline fills and stalls its input.
    initial
    begin
        wait (squeeze_start);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d calls outstanding.", expected_calls.size());
            $display("argmax_base_call_with_quality_tb NOT OK");
            $finish;
        end
    end

    task automatic wait_until_drained();
        while (pending_positions.size() > 0 || s_axis_tvalid || expected_calls.size() > 0)
            @(negedge clk);
    endtask

    task automatic queue_position(input position_t pos);
        pending_positions = {pending_positions, pos};
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct, input int count);
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
            queue_position(random_position());
        wait_until_drained();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        queue_position(make_position(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        queue_position(make_position(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        queue_position(make_position(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        queue_position(make_position(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        queue_position(make_position(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
        queue_position(make_position(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0));
        queue_position(make_position(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
        queue_position(make_position(16'h1000, 16'hC000, 16'h0100, 16'h0010, 16'hC000, 1'b1));
        queue_position(make_position(16'h0000, 16'h1234, 16'h8000, 16'h8000, 16'h7FFF, 1'b0));
        queue_position(make_position(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b0));
        queue_position(make_position(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        queue_position(make_position(16'h0000, 16'h0000, 16'h0000, 16'd65530, 16'h0000, 1'b0));
        queue_position(make_position(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd65529, 1'b0));
        queue_position(make_position(16'h0000, 16'd13479, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        queue_position(make_position(16'h0000, 16'h0000, 16'd13478, 16'h0000, 16'h0000, 1'b1));
        queue_position(make_position(16'd64881, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        queue_position(make_position(16'd64880, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        queue_position(make_position(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1));
        queue_position(make_position(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0));
        queue_position(make_position(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        wait_until_drained();

        run_random(0, 0, RANDOM_PER_SET);
        run_random(88, 0, RANDOM_PER_SET);
        run_random(0, 88, RANDOM_PER_SET);
        run_random(36, 36, RANDOM_PER_SET);

        @(negedge clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        squeeze_start = 1'b1;
        for (int n = 0; n < SQUEEZE_ITEMS; n++)
            queue_position(random_position());
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d base calls (%0d at top quality, %0d at zero quality,",
                 calls_checked, top_quality_calls, zero_quality_calls);
        $display("%0d sample ends); sender was stalled for %0d cycles; %0d mismatches.",
                 sample_ends, input_stalls, mismatches);
        if (mismatches == 0 && expected_calls.size() == 0)
            $display("argmax_base_call_with_quality_tb OK");
        else
            $display("argmax_base_call_with_quality_tb NOT OK");
        $finish;
    end

endmodule
